[design/handle_table_swap_remove_defines.svh]
// ----------------------------------------------------------------------------
// handle table assertion macros
// shared concurrent assertion forms, clocked on clk and quiet during reset
// ----------------------------------------------------------------------------
`ifndef HANDLE_TABLE_SWAP_REMOVE_DEFINES_SVH
`define HANDLE_TABLE_SWAP_REMOVE_DEFINES_SVH

// condition holds at every edge out of reset
`define HTSR_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent follows the antecedent through non-overlapping implication
`define HTSR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[design/htsr_pkg.sv]
// ----------------------------------------------------------------------------
// htsr_pkg
// operation codes and fixed port widths of the handle table
// ----------------------------------------------------------------------------
package htsr_pkg;

  localparam int OP_W      = 2;
  localparam int HANDLE_W  = 8;
  localparam int PAY_IO_W  = 32;
  localparam int LIVE_W    = 9;

  typedef logic [OP_W-1:0]     op_t;
  typedef logic [HANDLE_W-1:0] handle_t;
  typedef logic [PAY_IO_W-1:0] pay_io_t;
  typedef logic [LIVE_W-1:0]   live_cnt_t;

  localparam op_t OP_ADD    = 2'd0;
  localparam op_t OP_REMOVE = 2'd1;
  localparam op_t OP_LOOKUP = 2'd2;

endpackage

[design/htsr_ram.sv]
// ----------------------------------------------------------------------------
// htsr_ram
// simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module htsr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

[design/handle_table_swap_remove.sv]
// ----------------------------------------------------------------------------
// handle_table_swap_remove
// handle table: live ids map to slots of a dense payload array, removal
// swaps the last entry into the hole, freed ids are recycled in fifo order
// ----------------------------------------------------------------------------
//  channel | direction | fields
//  in      | input     | op, handle_id, payload
//  out     | output    | ok, given_id, found_payload, live_count
//
//  add ends in exec, remove/lookup in tail: each starts with a registered
//  read of the id map / fifo ram and lookup needs a second dependent read of
//  the dense ram; remove writes the id map twice through its single port.
//  one item is in flight at a time; in_ready is high only when idle.
//  no clearing pass after reset: the free fifo and the id map are qualified
//  by fill counters, so the block is ready as soon as reset is released.
//  a held result stalls the final state of the next item until it is taken.
`include "handle_table_swap_remove_defines.svh"

module handle_table_swap_remove #(
  parameter int NUM_IDS      = 256,
  parameter int PAYLOAD_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  htsr_pkg::op_t         in_op,
  input  htsr_pkg::handle_t     in_handle_id,
  input  htsr_pkg::pay_io_t     in_payload,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_ok,
  output htsr_pkg::handle_t     out_given_id,
  output htsr_pkg::pay_io_t     out_found_payload,
  output htsr_pkg::live_cnt_t   out_live_count
);
  import htsr_pkg::*;

  localparam int ID_W  = $clog2(NUM_IDS);
  localparam int CNT_W = $clog2(NUM_IDS + 1);
  localparam int SUM_W = CNT_W + 1;
  localparam int PB    = PAYLOAD_BITS;
  localparam int DW    = PB + ID_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_TAIL = 2'd2;

  // control state
  logic [1:0]       state_r, state_nxt;
  logic [CNT_W-1:0] dc_r, dc_nxt;
  logic [CNT_W-1:0] free_cnt_r, free_cnt_nxt;
  logic [ID_W-1:0]  head_r, head_nxt;
  logic [CNT_W-1:0] fill_r, fill_nxt;   // fifo slots ever written
  logic [CNT_W-1:0] pops_r, pops_nxt;   // ids ever handed out
  logic             out_valid_r, out_valid_nxt;

  // item registers
  op_t              op_r, op_nxt;
  logic [ID_W-1:0]  hid_r, hid_nxt;
  logic             in_range_r, in_range_nxt;
  logic             issued_r, issued_nxt;
  logic [PB-1:0]    pay_r, pay_nxt;
  logic             known_r, known_nxt;
  logic [ID_W-1:0]  slot_r, slot_nxt;

  // result registers
  logic             out_ok_r, out_ok_nxt;
  handle_t          out_given_id_r, out_given_id_nxt;
  pay_io_t          out_found_r, out_found_nxt;
  live_cnt_t        out_live_r, out_live_nxt;

  // memory ports
  logic             free_we;
  logic [ID_W-1:0]  free_waddr, free_wdata, free_rd;
  logic             dense_we;
  logic [ID_W-1:0]  dense_waddr, dense_raddr;
  logic [DW-1:0]    dense_wdata, dense_rd;
  logic             map_we;
  logic [ID_W-1:0]  map_waddr, map_raddr;
  logic [ID_W:0]    map_wdata, map_rd;

  // helpers
  logic [31:0]      hid32;
  logic [63:0]      pay64_in, pay64_out;
  logic [31:0]      given32, live32;
  logic             out_free, accept;
  logic             known_now, add_ok;
  logic [ID_W-1:0]  new_id, last_id, last_slot, head_inc;
  logic [SUM_W-1:0] tail_sum, tail_wrap;
  logic [ID_W-1:0]  tail_addr;

  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;

  assign hid32     = 32'(in_handle_id);
  assign pay64_in  = 64'(in_payload);
  assign pay64_out = 64'(dense_rd[PB-1:0]);

  assign known_now = in_range_r && issued_r && map_rd[ID_W];
  assign add_ok    = (free_cnt_r != '0) && (dc_r < CNT_W'(NUM_IDS));
  // fifo slots past the fill mark have never been written
  assign new_id    = (CNT_W'(head_r) < fill_r) ? free_rd : head_r;
  assign last_id   = dense_rd[DW-1:PB];
  assign last_slot = ID_W'(dc_r - 1'b1);
  assign head_inc  = (head_r == ID_W'(NUM_IDS - 1)) ? '0 : head_r + 1'b1;

  assign tail_sum  = SUM_W'(head_r) + SUM_W'(free_cnt_r);
  assign tail_wrap = (tail_sum >= SUM_W'(NUM_IDS)) ? tail_sum - SUM_W'(NUM_IDS) : tail_sum;
  assign tail_addr = tail_wrap[ID_W-1:0];

  assign map_raddr = hid32[ID_W-1:0];
  assign dense_raddr = (state_r == ST_EXEC) ? map_rd[ID_W-1:0] :
                       (state_r == ST_TAIL) ? slot_r : last_slot;

  always_comb begin
    state_nxt        = state_r;
    dc_nxt           = dc_r;
    free_cnt_nxt     = free_cnt_r;
    head_nxt         = head_r;
    fill_nxt         = fill_r;
    pops_nxt         = pops_r;
    op_nxt           = op_r;
    hid_nxt          = hid_r;
    in_range_nxt     = in_range_r;
    issued_nxt       = issued_r;
    pay_nxt          = pay_r;
    known_nxt        = known_r;
    slot_nxt         = slot_r;
    out_valid_nxt    = out_valid_r && !out_ready;
    out_ok_nxt       = out_ok_r;
    out_given_id_nxt = out_given_id_r;
    out_found_nxt    = out_found_r;
    out_live_nxt     = out_live_r;
    given32          = '0;
    live32           = '0;
    free_we          = 1'b0;
    free_waddr       = tail_addr;
    free_wdata       = hid_r;
    dense_we         = 1'b0;
    dense_waddr      = dc_r[ID_W-1:0];
    dense_wdata      = {new_id, pay_r};
    map_we           = 1'b0;
    map_waddr        = new_id;
    map_wdata        = {1'b1, dc_r[ID_W-1:0]};

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          op_nxt       = in_op;
          hid_nxt      = hid32[ID_W-1:0];
          in_range_nxt = hid32 < 32'(NUM_IDS);
          issued_nxt   = hid32 < 32'(pops_r);
          pay_nxt      = pay64_in[PB-1:0];
          state_nxt    = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (op_r == OP_REMOVE || op_r == OP_LOOKUP) begin
          known_nxt = known_now;
          slot_nxt  = map_rd[ID_W-1:0];
          state_nxt = ST_TAIL;
          if (op_r == OP_REMOVE && known_now) begin
            // last entry moves into the hole, its id follows it
            dense_we    = 1'b1;
            dense_waddr = map_rd[ID_W-1:0];
            dense_wdata = dense_rd;
            map_we      = 1'b1;
            map_waddr   = last_id;
            map_wdata   = {1'b1, map_rd[ID_W-1:0]};
            dc_nxt      = dc_r - 1'b1;
            if (free_cnt_r < CNT_W'(NUM_IDS)) begin
              free_we      = 1'b1;
              free_cnt_nxt = free_cnt_r + 1'b1;
              fill_nxt     = (fill_r == CNT_W'(NUM_IDS)) ? fill_r : fill_r + 1'b1;
            end
          end
        end else if (out_free) begin
          // add, or an unused code that only reports
          given32 = '0;
          if (op_r == OP_ADD && add_ok) begin
            dense_we     = 1'b1;
            map_we       = 1'b1;
            head_nxt     = head_inc;
            free_cnt_nxt = free_cnt_r - 1'b1;
            dc_nxt       = dc_r + 1'b1;
            pops_nxt     = (pops_r == CNT_W'(NUM_IDS)) ? pops_r : pops_r + 1'b1;
            given32      = 32'(new_id);
          end
          live32           = 32'(dc_nxt);
          out_valid_nxt    = 1'b1;
          out_ok_nxt       = (op_r == OP_ADD) && add_ok;
          out_given_id_nxt = given32[HANDLE_W-1:0];
          out_found_nxt    = '0;
          out_live_nxt     = live32[LIVE_W-1:0];
          state_nxt        = ST_IDLE;
        end
      end
      ST_TAIL: begin
        if (out_free) begin
          if (op_r == OP_REMOVE && known_r) begin
            // cleared after the move so a self-move still ends not live
            map_we    = 1'b1;
            map_waddr = hid_r;
            map_wdata = {1'b0, slot_r};
          end
          live32           = 32'(dc_r);
          out_valid_nxt    = 1'b1;
          out_ok_nxt       = known_r;
          out_given_id_nxt = '0;
          out_found_nxt    = (op_r == OP_LOOKUP && known_r) ? pay64_out[PAY_IO_W-1:0] : '0;
          out_live_nxt     = live32[LIVE_W-1:0];
          state_nxt        = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      dc_r        <= '0;
      free_cnt_r  <= CNT_W'(NUM_IDS);
      head_r      <= '0;
      fill_r      <= '0;
      pops_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      dc_r        <= dc_nxt;
      free_cnt_r  <= free_cnt_nxt;
      head_r      <= head_nxt;
      fill_r      <= fill_nxt;
      pops_r      <= pops_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r           <= op_nxt;
    hid_r          <= hid_nxt;
    in_range_r     <= in_range_nxt;
    issued_r       <= issued_nxt;
    pay_r          <= pay_nxt;
    known_r        <= known_nxt;
    slot_r         <= slot_nxt;
    out_ok_r       <= out_ok_nxt;
    out_given_id_r <= out_given_id_nxt;
    out_found_r    <= out_found_nxt;
    out_live_r     <= out_live_nxt;
  end

  htsr_ram #(.WIDTH(ID_W), .DEPTH(NUM_IDS)) u_free_ram (
    .clk     (clk),
    .wr_en   (free_we),
    .wr_addr (free_waddr),
    .wr_data (free_wdata),
    .rd_addr (head_r),
    .rd_data (free_rd)
  );

  htsr_ram #(.WIDTH(DW), .DEPTH(NUM_IDS)) u_dense_ram (
    .clk     (clk),
    .wr_en   (dense_we),
    .wr_addr (dense_waddr),
    .wr_data (dense_wdata),
    .rd_addr (dense_raddr),
    .rd_data (dense_rd)
  );

  htsr_ram #(.WIDTH(ID_W + 1), .DEPTH(NUM_IDS)) u_map_ram (
    .clk     (clk),
    .wr_en   (map_we),
    .wr_addr (map_waddr),
    .wr_data (map_wdata),
    .rd_addr (map_raddr),
    .rd_data (map_rd)
  );

  assign out_valid         = out_valid_r;
  assign out_ok            = out_ok_r;
  assign out_given_id      = out_given_id_r;
  assign out_found_payload = out_found_r;
  assign out_live_count    = out_live_r;

  `HTSR_ASSERT_ALWAYS(a_count_sum, (32'(dc_r) + 32'(free_cnt_r)) == 32'(NUM_IDS), "live and free counts do not add up")
  `HTSR_ASSERT_ALWAYS(a_fill_le_pops, fill_r <= pops_r, "fifo written beyond ids handed out")
  `HTSR_ASSERT_NEXT(a_accept_exec, accept, state_r == ST_EXEC, "accepted item not executed")
  `HTSR_ASSERT_NEXT(a_remove_shrinks, (state_r == ST_EXEC) && (op_r == OP_REMOVE) && known_now, dc_r == $past(dc_r) - 1'b1, "remove did not shrink dense array")

endmodule
